// ===== src/rgbd_pkg.sv =====
package rgbd_pkg;

    localparam int MAX_VARS      = 16;
    localparam int MAX_CODE_BITS = 8;

    // variable / slot index width and a count that can hold MAX_VARS itself
    localparam int VAR_W = $clog2(MAX_VARS);
    localparam int CNT_W = VAR_W + 1;
    // bit position inside a code and a length that can hold MAX_CODE_BITS
    localparam int BIT_W = $clog2(MAX_CODE_BITS);
    localparam int LEN_W = BIT_W + 1;
    localparam int ACC_W = MAX_CODE_BITS;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_INPUT_SLOTS      = 3'd0,
        REG_INPUT_VAR_COUNT  = 3'd1,
        REG_OUTPUT_VAR_COUNT = 3'd2,
        REG_IN_VAR_BITS      = 3'd3,
        REG_OUT_VAR_BITS     = 3'd4,
        REG_IN_SET_BITS      = 3'd5,
        REG_OUT_SET_BITS     = 3'd6,
        REG_FIXED_VARS       = 3'd7
    } t_reg_idx;

    // configuration, already clamped to its legal range
    typedef struct packed {
        logic [CNT_W-1:0] in_slots;
        logic [CNT_W-1:0] in_var_count;
        logic [CNT_W-1:0] out_var_count;
        logic [LEN_W-1:0] in_var_bits;
        logic [LEN_W-1:0] out_var_bits;
        logic [LEN_W-1:0] in_set_bits;
        logic [LEN_W-1:0] out_set_bits;
        logic             fixed_vars;
    } t_cfg;

    typedef struct packed {
        logic                    is_output_slot;
        logic [3:0]              slot_index;
        logic signed [4:0]       var_number;
        logic [7:0]              set_number;
        logic                    genome_end;
        logic                    length_error;
    } t_result;

    localparam logic signed [4:0] VAR_NONE = 5'sb11111;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (32'(v) > MAX_VARS) begin
            r = CNT_W'(MAX_VARS);
        end else begin
            r = CNT_W'(v);
        end
        return r;
    endfunction

    function automatic logic [LEN_W-1:0] clamp_bits(input logic [3:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (32'(v) > MAX_CODE_BITS) begin
            r = LEN_W'(MAX_CODE_BITS);
        end else begin
            r = LEN_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== src/rule_genome_bit_decoder.sv =====
// Serial rule genome decoder. Takes one genome bit per request on the slave
// stream (tdata[0] = bit, tlast = final bit) and emits one result per slot:
// input_slots input slots, then output_var_count output slots, each a
// variable code then a set code, LSB first. Variable number reads -1 when the
// code is out of range or repeats within its section; fixed vars makes input
// slots read their slot index. A tlast anywhere but the final bit, or a final
// bit without tlast, gives a result with length_error set; either way the
// genome closes (genome_end) and decoding restarts. Rate: one bit per clock
// unless the output stalls; a result goes via the input register and the
// decode step into the output register. The user must write configuration
// through i_cfg_* only while no bits are in flight; the block does not
// enforce it. Register index follows the list: slots, in var count, out var
// count, in/out var bits, in/out set bits, fixed vars.
module rule_genome_bit_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [rgbd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [rgbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // bit stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [0] bit_req, [7:1] zero
    input  logic                            s_axis_tlast,   // last_bit
    // slot results out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // [3:0] slot_index,
                                                            // [8:4] var_number,
                                                            // [16:9] set_number, rest 0
    output logic [1:0]                      m_axis_tuser,   // [0] is_output_slot,
                                                            // [1] length_error
    output logic                            m_axis_tlast    // genome_end
);
    import rgbd_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    res_valid;

    logic    r_in_valid;
    logic    r_in_bit;
    logic    r_in_last;
    logic    r_out_valid;
    t_result r_out;
    logic    advance;

    rgbd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // the held bit moves into the decoder when the output register has room
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_bit  <= s_axis_tdata[0];
            r_in_last <= s_axis_tlast;
        end
    end

    rgbd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_valid     (advance),
        .i_bit       (r_in_bit),
        .i_last      (r_in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // output register: most bits produce no result, so it only loads on one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out.set_number, r_out.var_number, r_out.slot_index};
    assign m_axis_tuser  = {r_out.length_error, r_out.is_output_slot};
    assign m_axis_tlast  = r_out.genome_end;

endmodule

// ===== src/rgbd_cfg.sv =====
module rgbd_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rgbd_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [rgbd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output rgbd_pkg::t_cfg                       o_cfg
);
    import rgbd_pkg::*;

    t_cfg r_cfg;

    // values are clamped on the way in; there is no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_slots      <= clamp_count(CFG_DATA_W'(16));
            r_cfg.in_var_count  <= clamp_count(CFG_DATA_W'(16));
            r_cfg.out_var_count <= clamp_count(CFG_DATA_W'(1));
            r_cfg.in_var_bits   <= clamp_bits(4'd4);
            r_cfg.out_var_bits  <= clamp_bits(4'd4);
            r_cfg.in_set_bits   <= clamp_bits(4'd4);
            r_cfg.out_set_bits  <= clamp_bits(4'd4);
            r_cfg.fixed_vars    <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_INPUT_SLOTS:      r_cfg.in_slots      <= clamp_count(i_cfg_data);
                REG_INPUT_VAR_COUNT:  r_cfg.in_var_count  <= clamp_count(i_cfg_data);
                REG_OUTPUT_VAR_COUNT: r_cfg.out_var_count <= clamp_count(i_cfg_data);
                REG_IN_VAR_BITS:      r_cfg.in_var_bits   <= clamp_bits(i_cfg_data[3:0]);
                REG_OUT_VAR_BITS:     r_cfg.out_var_bits  <= clamp_bits(i_cfg_data[3:0]);
                REG_IN_SET_BITS:      r_cfg.in_set_bits   <= clamp_bits(i_cfg_data[3:0]);
                REG_OUT_SET_BITS:     r_cfg.out_set_bits  <= clamp_bits(i_cfg_data[3:0]);
                REG_FIXED_VARS:       r_cfg.fixed_vars    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/rgbd_decode.sv =====
module rgbd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rgbd_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  logic              i_bit,
    input  logic              i_last,
    output logic              o_res_valid,
    output rgbd_pkg::t_result o_res
);
    import rgbd_pkg::*;

    logic [BIT_W-1:0]    r_bif, n_bif;
    logic                r_setf, n_setf;
    logic [VAR_W-1:0]    r_slot, n_slot;
    logic                r_outsec, n_outsec;
    logic [ACC_W-1:0]    r_var_acc, n_var_acc;
    logic [ACC_W-1:0]    r_set_acc, n_set_acc;
    logic [MAX_VARS-1:0] r_used_in, n_used_in;
    logic [MAX_VARS-1:0] r_used_out, n_used_out;

    logic [LEN_W-1:0]    field_len;
    logic [CNT_W-1:0]    slot_count;
    logic [CNT_W-1:0]    var_count;
    logic [ACC_W-1:0]    bit_mask;
    logic [ACC_W-1:0]    acc_var;
    logic [ACC_W-1:0]    acc_set;
    logic [LEN_W-1:0]    bif_next;
    logic                field_done;
    logic [CNT_W-1:0]    slot_next;
    logic [VAR_W-1:0]    var_idx;
    logic signed [4:0]   var_out;
    logic                at_end;
    logic                clear;

    always_comb begin
        field_len  = r_outsec ? (r_setf ? i_cfg.out_set_bits : i_cfg.out_var_bits)
                              : (r_setf ? i_cfg.in_set_bits  : i_cfg.in_var_bits);
        slot_count = r_outsec ? i_cfg.out_var_count : i_cfg.in_slots;
        var_count  = r_outsec ? i_cfg.out_var_count : i_cfg.in_var_count;

        bit_mask   = ACC_W'(i_bit) << r_bif;
        acc_var    = r_setf ? r_var_acc : (r_var_acc | bit_mask);
        acc_set    = r_setf ? (r_set_acc | bit_mask) : r_set_acc;
        bif_next   = LEN_W'(r_bif) + LEN_W'(1);
        field_done = (bif_next >= field_len);
        slot_next  = CNT_W'(r_slot) + CNT_W'(1);
        var_idx    = acc_var[VAR_W-1:0];

        n_bif      = r_bif;
        n_setf     = r_setf;
        n_slot     = r_slot;
        n_outsec   = r_outsec;
        n_var_acc  = acc_var;
        n_set_acc  = acc_set;
        n_used_in  = r_used_in;
        n_used_out = r_used_out;
        var_out    = VAR_NONE;
        at_end     = 1'b0;
        clear      = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (!(field_done && r_setf)) begin
            // still inside the slot
            if (field_done) begin
                n_bif  = '0;
                n_setf = 1'b1;
            end else begin
                n_bif  = bif_next[BIT_W-1:0];
            end
            if (i_last) begin
                // early end: bare error result
                o_res_valid        = 1'b1;
                o_res.genome_end   = 1'b1;
                o_res.length_error = 1'b1;
                clear              = 1'b1;
            end
        end else begin
            // slot complete
            if (!r_outsec && i_cfg.fixed_vars) begin
                var_out = 5'(r_slot);
            end else if (acc_var >= ACC_W'(var_count)) begin
                var_out = VAR_NONE;
            end else if (r_outsec) begin
                if (r_used_out[var_idx]) begin
                    var_out = VAR_NONE;
                end else begin
                    n_used_out[var_idx] = 1'b1;
                    var_out = 5'(var_idx);
                end
            end else begin
                if (r_used_in[var_idx]) begin
                    var_out = VAR_NONE;
                end else begin
                    n_used_in[var_idx] = 1'b1;
                    var_out = 5'(var_idx);
                end
            end

            n_bif     = '0;
            n_setf    = 1'b0;
            n_var_acc = '0;
            n_set_acc = '0;
            if (slot_next >= slot_count) begin
                n_slot = '0;
                if (r_outsec) begin
                    at_end = 1'b1;
                end else begin
                    n_outsec = 1'b1;
                end
            end else begin
                n_slot = slot_next[VAR_W-1:0];
            end

            o_res_valid          = 1'b1;
            o_res.is_output_slot = r_outsec;
            o_res.slot_index     = 4'(r_slot);
            o_res.var_number     = var_out;
            o_res.set_number     = 8'(acc_set);
            o_res.genome_end     = i_last | at_end;
            o_res.length_error   = i_last ^ at_end;
            clear                = i_last | at_end;
        end

        if (clear) begin
            n_bif      = '0;
            n_setf     = 1'b0;
            n_slot     = '0;
            n_outsec   = 1'b0;
            n_var_acc  = '0;
            n_set_acc  = '0;
            n_used_in  = '0;
            n_used_out = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bif      <= '0;
            r_setf     <= 1'b0;
            r_slot     <= '0;
            r_outsec   <= 1'b0;
            r_var_acc  <= '0;
            r_set_acc  <= '0;
            r_used_in  <= '0;
            r_used_out <= '0;
        end else if (i_valid) begin
            r_bif      <= n_bif;
            r_setf     <= n_setf;
            r_slot     <= n_slot;
            r_outsec   <= n_outsec;
            r_var_acc  <= n_var_acc;
            r_set_acc  <= n_set_acc;
            r_used_in  <= n_used_in;
            r_used_out <= n_used_out;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_res_valid && o_res.genome_end) |=>
        (r_slot == '0 && !r_outsec && r_used_in == '0 && r_used_out == '0))
        else $error("genome end did not clear decoder state");

    a_slot_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_res_valid && !o_res.genome_end) |=>
        (r_bif == '0 && !r_setf && r_var_acc == '0 && r_set_acc == '0))
        else $error("slot end did not restart the code fields");

    a_acc_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_setf && r_bif == '0) |-> (r_var_acc == '0 && r_set_acc == '0))
        else $error("accumulators not clear at slot start");
`endif

endmodule
